>>> sv/fpa_pkg.sv
package fpa_pkg;

   typedef enum logic [3:0] {
      ACT_ADD      = 4'd0,
      ACT_SUB      = 4'd1,
      ACT_MUL      = 4'd2,
      ACT_DIV      = 4'd3,
      ACT_MIN      = 4'd4,
      ACT_MAX      = 4'd5,
      ACT_INC      = 4'd6,
      ACT_DEC      = 4'd7,
      ACT_TO_INT   = 4'd8,
      ACT_FROM_INT = 4'd9
   } act_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] act;
      logic       neg;
      logic       neg_a;
      logic       lt;
      logic       eq;
      logic       gt;
      logic       dz;
   } ctrl_type;

endpackage

>>> sv/fpa_if.sv
interface fpa_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic [3:0]                  action;
   logic signed [WORD_BITS-1:0] operand_a;
   logic signed [WORD_BITS-1:0] operand_b;
   modport source (output valid, action, operand_a, operand_b, input ready);
   modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] result;
   logic                        less;
   logic                        equal;
   logic                        greater;
   logic                        div_zero;
   logic                        overflow;
   modport source (output valid, result, less, equal, greater, div_zero, overflow,
                   input ready);
   modport sink (input valid, result, less, equal, greater, div_zero, overflow,
                 output ready);
endinterface

>>> sv/fpa_prep.sv
module fpa_prep #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [3:0]                    in_act,
   input  logic [WORD_BITS-1:0]          in_a,
   input  logic [WORD_BITS-1:0]          in_b,
   output fpa_pkg::ctrl_type             ctrl_ff,
   output logic [WORD_BITS-1:0]          res_ff,
   output logic                          ovf_ff,
   output logic [2*WORD_BITS-1:0]        prod_ff,
   output logic [WORD_BITS-1:0]          mb_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0] num_ff
);
   localparam int W = WORD_BITS;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   fpa_pkg::ctrl_type c1_in, c1_ff;
   logic [W-1:0] r1_in, r1_ff, ma_in, ma_ff, mb_in, mb1_ff;
   logic         o1_in, o1_ff;
   logic         na, nb;
   logic [W-1:0] sum, dif;
   logic signed [W-1:0] sa, sb;

   always_comb begin
      sa = signed'(in_a);
      sb = signed'(in_b);
      na = in_a[W-1];
      nb = in_b[W-1];
      ma_in = na ? W'(-in_a) : in_a;
      mb_in = nb ? W'(-in_b) : in_b;
      sum = in_a + in_b;
      dif = in_a - in_b;
      c1_in.valid = in_valid;
      c1_in.act = in_act;
      c1_in.neg = na ^ nb;
      c1_in.neg_a = na;
      c1_in.lt = sa < sb;
      c1_in.eq = in_a == in_b;
      c1_in.gt = sa > sb;
      c1_in.dz = (mb_in == '0);
      r1_in = '0;
      o1_in = 1'b0;
      unique case (in_act)
         fpa_pkg::ACT_ADD: begin
            r1_in = sum;
            if (na == nb && sum[W-1] != na) begin
               o1_in = 1'b1;
               r1_in = na ? MINV : MAXV;
            end
         end
         fpa_pkg::ACT_SUB: begin
            r1_in = dif;
            if (na != nb && dif[W-1] != na) begin
               o1_in = 1'b1;
               r1_in = na ? MINV : MAXV;
            end
         end
         fpa_pkg::ACT_MIN: r1_in = (sa < sb) ? in_a : in_b;
         fpa_pkg::ACT_MAX: r1_in = (sa > sb) ? in_a : in_b;
         fpa_pkg::ACT_INC: begin
            o1_in = (in_a == MAXV);
            r1_in = o1_in ? MAXV : in_a + W'(1);
         end
         fpa_pkg::ACT_DEC: begin
            o1_in = (in_a == MINV);
            r1_in = o1_in ? MINV : in_a - W'(1);
         end
         fpa_pkg::ACT_TO_INT: r1_in = W'(sa >>> FRAC_BITS);
         fpa_pkg::ACT_FROM_INT: begin
            if (!na && sa > (signed'(MAXV) >>> FRAC_BITS)) begin
               o1_in = 1'b1;
               r1_in = MAXV;
            end else if (na && sa < (signed'(MINV) >>> FRAC_BITS)) begin
               o1_in = 1'b1;
               r1_in = MINV;
            end else begin
               r1_in = in_a << FRAC_BITS;
            end
         end
         default: r1_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         c1_ff <= c1_in;
         ctrl_ff <= c1_ff;
      end
      if (en) begin
         r1_ff <= r1_in;
         o1_ff <= o1_in;
         ma_ff <= ma_in;
         mb1_ff <= mb_in;
         res_ff <= r1_ff;
         ovf_ff <= o1_ff;
         prod_ff <= (2*W)'(ma_ff) * (2*W)'(mb1_ff);
         mb_ff <= mb1_ff;
         num_ff <= {ma_ff, {FRAC_BITS{1'b0}}};
      end
   end
endmodule

>>> sv/fpa_div_step.sv
module fpa_div_step #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  fpa_pkg::ctrl_type              ctrl_in,
   input  logic [WORD_BITS-1:0]           res_in,
   input  logic                           ovf_in,
   input  logic [2*WORD_BITS-1:0]         prod_in,
   input  logic [WORD_BITS-1:0]           mb_in,
   input  logic [WORD_BITS-1:0]           rem_in,
   input  logic [WORD_BITS+FRAC_BITS-1:0] num_in,
   input  logic [WORD_BITS+FRAC_BITS-1:0] quot_in,
   output fpa_pkg::ctrl_type              ctrl_ff,
   output logic [WORD_BITS-1:0]           res_ff,
   output logic                           ovf_ff,
   output logic [2*WORD_BITS-1:0]         prod_ff,
   output logic [WORD_BITS-1:0]           mb_ff,
   output logic [WORD_BITS-1:0]           rem_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0] num_ff,
   output logic [WORD_BITS+FRAC_BITS-1:0] quot_ff
);
   localparam int W = WORD_BITS;
   localparam int QB = WORD_BITS + FRAC_BITS;

   logic [W:0]   trial;
   logic         fits;
   logic [W-1:0] rem_in_nx;

   always_comb begin
      trial = {rem_in, num_in[QB-1]};
      fits = trial >= {1'b0, mb_in};
      rem_in_nx = fits ? W'(trial - {1'b0, mb_in}) : trial[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
      if (en) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
         prod_ff <= prod_in;
         mb_ff <= mb_in;
         rem_ff <= rem_in_nx;
         num_ff <= {num_in[QB-2:0], 1'b0};
         quot_ff <= {quot_in[QB-2:0], fits};
      end
   end
endmodule

>>> sv/fpa_finish.sv
module fpa_finish #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  fpa_pkg::ctrl_type              ctrl_in,
   input  logic [WORD_BITS-1:0]           res_in,
   input  logic                           ovf_in,
   input  logic [2*WORD_BITS-1:0]         prod_in,
   input  logic [WORD_BITS-1:0]           mb_in,
   input  logic [WORD_BITS-1:0]           rem_in,
   input  logic [WORD_BITS+FRAC_BITS-1:0] quot_in,
   output logic                           valid_ff,
   output logic [WORD_BITS-1:0]           result_ff,
   output logic                           less_ff,
   output logic                           equal_ff,
   output logic                           greater_ff,
   output logic                           dz_ff,
   output logic                           ovf_ff
);
   localparam int W = WORD_BITS;
   localparam int QB = WORD_BITS + FRAC_BITS;
   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   logic [2*W:0]  psum, pmag;
   logic [QB:0]   dmag;
   logic [2*W:0]  lim;
   logic          rnd;
   logic [W-1:0]  result_in;
   logic          ovf_in_nx, dz_in;

   always_comb begin
      lim = ctrl_in.neg ? (2*W+1)'(MINV) : (2*W+1)'(MAXV);
      psum = {1'b0, prod_in} + ((2*W+1)'(1) << (FRAC_BITS - 1));
      pmag = psum >> FRAC_BITS;
      rnd = {rem_in, 1'b0} >= {1'b0, mb_in};
      dmag = {1'b0, quot_in} + (QB+1)'(rnd);
      result_in = res_in;
      ovf_in_nx = ovf_in;
      dz_in = 1'b0;
      unique case (ctrl_in.act)
         fpa_pkg::ACT_MUL: begin
            if (pmag > lim) begin
               ovf_in_nx = 1'b1;
               result_in = ctrl_in.neg ? MINV : MAXV;
            end else begin
               result_in = ctrl_in.neg ? W'(-pmag[W-1:0]) : pmag[W-1:0];
            end
         end
         fpa_pkg::ACT_DIV: begin
            if (ctrl_in.dz) begin
               dz_in = 1'b1;
               ovf_in_nx = 1'b1;
               result_in = ctrl_in.neg_a ? MINV : MAXV;
            end else if ((2*W+1)'(dmag) > lim) begin
               ovf_in_nx = 1'b1;
               result_in = ctrl_in.neg ? MINV : MAXV;
            end else begin
               result_in = ctrl_in.neg ? W'(-dmag[W-1:0]) : dmag[W-1:0];
            end
         end
         default: result_in = res_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctrl_in.valid;
      end
      if (en) begin
         result_ff <= result_in;
         less_ff <= ctrl_in.lt;
         equal_ff <= ctrl_in.eq;
         greater_ff <= ctrl_in.gt;
         dz_ff <= dz_in;
         ovf_ff <= ovf_in_nx;
      end
   end
endmodule

>>> sv/fixed_point_alu_q24_8.sv
// Channel | Direction | Fields
// req     | in        | action, operand_a, operand_b
// rsp     | out       | result, less, equal, greater, div_zero, overflow
//
// A beat enters every cycle unless a stalled result holds the pipeline; it passes
// the prep stage, the divider (one quotient bit per stage) and the finish stage.
// Reset is synchronous and clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
module fixed_point_alu_q24_8 #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input logic clock,
   input logic reset,
   fpa_req_if.sink   req,
   fpa_rsp_if.source rsp
);
   localparam int W = WORD_BITS;
   localparam int QB = WORD_BITS + FRAC_BITS;

   logic en;
   fpa_pkg::ctrl_type   ctrl_s [QB+1];
   logic [W-1:0]        res_s  [QB+1];
   logic                ovf_s  [QB+1];
   logic [2*W-1:0]      prod_s [QB+1];
   logic [W-1:0]        mb_s   [QB+1];
   logic [W-1:0]        rem_s  [QB+1];
   logic [QB-1:0]       num_s  [QB+1];
   logic [QB-1:0]       quot_s [QB+1];
   logic                out_v_ff;

   assign en = !out_v_ff || rsp.ready;
   assign req.ready = en;
   assign rem_s[0] = '0;
   assign quot_s[0] = '0;

   fpa_prep #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_prep (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req.valid), .in_act(req.action),
      .in_a(req.operand_a), .in_b(req.operand_b),
      .ctrl_ff(ctrl_s[0]), .res_ff(res_s[0]), .ovf_ff(ovf_s[0]),
      .prod_ff(prod_s[0]), .mb_ff(mb_s[0]), .num_ff(num_s[0])
   );

   for (genvar k = 0; k < QB; k++) begin : g_div
      fpa_div_step #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_step (
         .clock(clock), .reset(reset), .en(en),
         .ctrl_in(ctrl_s[k]), .res_in(res_s[k]), .ovf_in(ovf_s[k]),
         .prod_in(prod_s[k]), .mb_in(mb_s[k]), .rem_in(rem_s[k]),
         .num_in(num_s[k]), .quot_in(quot_s[k]),
         .ctrl_ff(ctrl_s[k+1]), .res_ff(res_s[k+1]), .ovf_ff(ovf_s[k+1]),
         .prod_ff(prod_s[k+1]), .mb_ff(mb_s[k+1]), .rem_ff(rem_s[k+1]),
         .num_ff(num_s[k+1]), .quot_ff(quot_s[k+1])
      );
   end

   fpa_finish #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_finish (
      .clock(clock), .reset(reset), .en(en),
      .ctrl_in(ctrl_s[QB]), .res_in(res_s[QB]), .ovf_in(ovf_s[QB]),
      .prod_in(prod_s[QB]), .mb_in(mb_s[QB]), .rem_in(rem_s[QB]),
      .quot_in(quot_s[QB]),
      .valid_ff(out_v_ff), .result_ff(rsp.result), .less_ff(rsp.less),
      .equal_ff(rsp.equal), .greater_ff(rsp.greater), .dz_ff(rsp.div_zero),
      .ovf_ff(rsp.overflow)
   );

   assign rsp.valid = out_v_ff;
endmodule
